// ===== hw/rtl/slew_limited_position_framer_assert.svh =====
// assertion macros used by the port checker
`ifndef SLEW_LIMITED_POSITION_FRAMER_ASSERT_SVH
`define SLEW_LIMITED_POSITION_FRAMER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slf check failed");

// antecedent implies consequent in the next cycle
`define SLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slf check failed");

`endif

// ===== hw/rtl/slf_pkg.sv =====
// shared types and constants of the slew limited position framer
package slf_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int TARGET_FIELDS = 4;
  localparam int POS_W         = 16;

  localparam logic [7:0] HDR_MOVE  = 8'hA1;
  localparam logic [7:0] HDR_ZERO  = 8'hA2;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam logic [POS_W-1:0] STEP_RESET = 16'd1;
  localparam logic [POS_W-1:0] TOL_RESET  = 16'd4;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TICK = 2'd1,
    OP_ZERO = 2'd2
  } slf_op_t;

  typedef enum logic [0:0] {
    REG_STEP = 1'b0,
    REG_TOL  = 1'b1
  } slf_reg_t;

  // per-cycle commands sent to every cell of the chain
  typedef struct packed {
    logic load_goal;
    logic tick;
    logic load_zero;
    logic shift;
  } slf_cell_ctl_t;

endpackage

// ===== hw/rtl/slf_cmd_if.sv =====
// request channel carrying the opcode and the channel targets
interface slf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] target_0;
  logic [15:0] target_1;
  logic [15:0] target_2;
  logic [15:0] target_3;

  modport source (output valid, opcode, target_0, target_1, target_2, target_3,
                  input ready);
  modport sink (input valid, opcode, target_0, target_1, target_2, target_3,
                output ready);
endinterface

// ===== hw/rtl/slf_frame_if.sv =====
// request channel carrying one frame byte per request
interface slf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== hw/rtl/slew_limited_position_framer.sv =====
// top level: config registers, frame sequencer and the chain of channel cells
//
//  channel | dir | handshake      | payload
//  cmd     | in  | valid / ready  | opcode, target_0..target_3
//  frame   | out | valid / ready  | frame_byte, last_byte
//  apb     | in  | psel / penable | paddr, pwdata, prdata (pready tied high)
//
// a tick or zero-frame request is accepted, then one byte per cycle goes into the
// output register while frame is not stalled, paced by the byte shift through the
// cell chain; the next request is taken once the checksum byte is registered.
// load, idle tick and unused opcodes give no bytes.
// reset is synchronous; stalls on frame hold the sequencer and the chain.
module slew_limited_position_framer
  import slf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  slf_cmd_if.sink     cmd,
  slf_frame_if.source frame
);

  localparam int BODY_BYTES = 2 * CHANNELS;
  localparam int CNT_W      = (BODY_BYTES > 1) ? $clog2(BODY_BYTES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_BODY = 4'b0100,
    ST_SUM  = 4'b1000
  } slf_state_t;

  slf_state_t       state;
  logic [POS_W-1:0] step_size;
  logic [POS_W-1:0] done_tolerance;
  logic             ramp_active;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;
  logic [7:0]       hdr;
  logic [7:0]       sum;
  logic [CNT_W-1:0] cnt;

  logic             cfg_wr;
  logic             cmd_fire;
  logic             advance;
  logic             start_tick;
  logic             start_zero;
  logic             arrived;
  slf_cell_ctl_t    ctl;
  logic [7:0]       link [CHANNELS+1];
  logic [POS_W-1:0] goal_w [CHANNELS];
  logic [POS_W-1:0] tgt [TARGET_FIELDS];
  logic [CHANNELS-1:0] tol_ok;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (slf_reg_t'(paddr[2]))
      REG_STEP: prdata = {16'd0, step_size};
      REG_TOL:  prdata = {16'd0, done_tolerance};
      default:  prdata = '0;
    endcase
  end

  // request decode
  assign cmd.ready  = (state == ST_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign start_tick = cmd_fire && (slf_op_t'(cmd.opcode) == OP_TICK) && ramp_active;
  assign start_zero = cmd_fire && (slf_op_t'(cmd.opcode) == OP_ZERO);
  assign advance    = !out_valid || frame.ready;

  assign ctl.load_goal = cmd_fire && (slf_op_t'(cmd.opcode) == OP_LOAD);
  assign ctl.tick      = start_tick;
  assign ctl.load_zero = start_zero;
  assign ctl.shift     = (state == ST_BODY) && advance;

  // target fields feed the first cells, later cells load zero
  assign tgt[0] = cmd.target_0;
  assign tgt[1] = cmd.target_1;
  assign tgt[2] = cmd.target_2;
  assign tgt[3] = cmd.target_3;

  // chain of channel cells, bytes move toward cell 0
  assign link[CHANNELS] = 8'h00;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    if (i < TARGET_FIELDS) begin : g_tgt
      assign goal_w[i] = tgt[i];
    end else begin : g_zero
      assign goal_w[i] = '0;
    end

    slf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .step     (step_size),
      .tol      (done_tolerance),
      .goal_in  (goal_w[i]),
      .byte_in  (link[i+1]),
      .byte_out (link[i]),
      .in_tol   (tol_ok[i])
    );
  end

  assign arrived = &tol_ok;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step_size      <= STEP_RESET;
      done_tolerance <= TOL_RESET;
      ramp_active    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (slf_reg_t'(paddr[2]))
          REG_STEP: step_size      <= pwdata[POS_W-1:0];
          REG_TOL:  done_tolerance <= pwdata[POS_W-1:0];
          default:  ;
        endcase
      end
      if (ctl.load_goal) begin
        ramp_active <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (out_valid && frame.ready) begin
            out_valid <= 1'b0;
          end
          if (start_tick || start_zero) begin
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (advance) begin
            out_valid <= 1'b1;
            state     <= ST_BODY;
          end
        end
        ST_BODY: begin
          if (advance && (cnt == CNT_W'(BODY_BYTES - 1))) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (advance) begin
            state <= ST_IDLE;
            if ((hdr == HDR_MOVE) && arrived) begin
              ramp_active <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // frame payload: header, body bytes and running checksum
  always_ff @(posedge clk) begin
    if (start_tick) begin
      hdr <= HDR_MOVE;
    end else if (start_zero) begin
      hdr <= HDR_ZERO;
    end
    if (advance) begin
      unique case (state)
        ST_HEAD: begin
          out_byte <= hdr;
          out_last <= 1'b0;
          sum      <= hdr;
          cnt      <= '0;
        end
        ST_BODY: begin
          out_byte <= link[0];
          out_last <= 1'b0;
          sum      <= sum + link[0];
          cnt      <= cnt + CNT_W'(1);
        end
        ST_SUM: begin
          out_byte <= sum;
          out_last <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign frame.valid      = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.last_byte  = out_last;

endmodule

// ===== hw/rtl/slf_cell.sv =====
// one channel cell: position ramp, tolerance check and frame byte shift stage
module slf_cell
  import slf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  slf_cell_ctl_t    ctl,
  input  logic [POS_W-1:0] step,
  input  logic [POS_W-1:0] tol,
  input  logic [POS_W-1:0] goal_in,
  input  logic [7:0]       byte_in,
  output logic [7:0]       byte_out,
  output logic             in_tol
);

  logic [POS_W-1:0] cur;
  logic [POS_W-1:0] goal;
  logic [POS_W-1:0] shreg;
  logic [POS_W-1:0] cur_next;
  logic signed [POS_W+1:0] delta;
  logic signed [POS_W+1:0] step_s;
  logic [POS_W:0] delta_abs;

  // signed distance to goal and the slew-limited move
  always_comb begin
    delta  = $signed({2'b00, goal}) - $signed({2'b00, cur});
    step_s = $signed({2'b00, step});
    priority if (delta > step_s) begin
      cur_next = cur + step;
    end else if (delta < -step_s) begin
      cur_next = cur - step;
    end else begin
      cur_next = goal;
    end
  end

  // arrival check on the stored position
  always_comb begin
    delta_abs = delta[POS_W+1] ? (POS_W+1)'(0) - delta[POS_W:0] : delta[POS_W:0];
    in_tol    = (delta_abs <= {1'b0, tol});
  end

  // position and goal state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      goal <= '0;
    end else begin
      if (ctl.tick) begin
        cur <= cur_next;
      end
      if (ctl.load_goal) begin
        goal <= goal_in;
      end
    end
  end

  // byte shift stage, high byte leaves toward the chain head
  always_ff @(posedge clk) begin
    priority if (ctl.tick) begin
      shreg <= cur_next;
    end else if (ctl.load_zero) begin
      shreg <= {FILL_BYTE, FILL_BYTE};
    end else if (ctl.shift) begin
      shreg <= {shreg[7:0], byte_in};
    end
  end

  assign byte_out = shreg[POS_W-1:8];

endmodule

// ===== hw/rtl/slf_checker.sv =====
// port-level checks of the framer, attached to the top level by bind
`include "slew_limited_position_framer_assert.svh"

module slf_checker
  import slf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_opcode,
  input logic       frame_valid,
  input logic       frame_ready,
  input logic [7:0] frame_byte,
  input logic       last_byte
);

  logic cmd_fire;
  assign cmd_fire = cmd_valid && cmd_ready;

  // no new request while a frame is still being sent
  `SLF_ASSERT_SAME(a_busy_midframe, clk, rst, frame_valid && !last_byte, !cmd_ready)

  // a zero frame request always starts a frame
  `SLF_ASSERT_NEXT(a_zero_busy, clk, rst, cmd_fire && (cmd_opcode == OP_ZERO), !cmd_ready)

  // a load gives no bytes and leaves the block ready
  `SLF_ASSERT_NEXT(a_load_ready, clk, rst, cmd_fire && (cmd_opcode == OP_LOAD), cmd_ready)

  // a stalled frame byte holds
  `SLF_ASSERT_NEXT(a_frame_hold, clk, rst, frame_valid && !frame_ready,
                   frame_valid && $stable(frame_byte) && $stable(last_byte))

endmodule

bind slew_limited_position_framer slf_checker u_slf_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_opcode  (cmd.opcode),
  .frame_valid (frame.valid),
  .frame_ready (frame.ready),
  .frame_byte  (frame.frame_byte),
  .last_byte   (frame.last_byte)
);

// ===== test/slf_frame_checker.sv =====
// checker that predicts the frame bytes of the slew limited position framer and compares them
module slf_frame_checker
  import slf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  slf_cmd_if          cmd,
  slf_frame_if        frame,
  output int unsigned failures,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // mirrored block state and register copies
  logic [POS_W-1:0] step;
  logic [POS_W-1:0] tol;
  logic [POS_W-1:0] position [CHANNELS];
  logic [POS_W-1:0] goal [CHANNELS];
  logic             ramping;

  frame_beat_t expected_beats [$];
  int unsigned fail_count = 0;

  // append one full frame: header, two bytes per channel, running checksum
  task automatic queue_frame(input logic [7:0] header, input logic fill);
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = header;
    expected_beats.push_back('{header, 1'b0});
    for (int ch = 0; ch < CHANNELS; ch++) begin
      hi = fill ? FILL_BYTE : position[ch][15:8];
      lo = fill ? FILL_BYTE : position[ch][7:0];
      expected_beats.push_back('{hi, 1'b0});
      expected_beats.push_back('{lo, 1'b0});
      sum = sum + hi + lo;
    end
    expected_beats.push_back('{sum, 1'b1});
  endtask

  // apply one accepted request to the mirrored state
  task automatic take_request(input logic [1:0] op, input logic [4*POS_W-1:0] targets);
    int  gap;
    int  limit;
    bit  arrived;
    case (op)
      OP_LOAD: begin
        for (int ch = 0; ch < CHANNELS; ch++)
          goal[ch] = (ch < TARGET_FIELDS) ? targets[ch*POS_W +: POS_W] : '0;
        ramping = 1'b1;
      end
      OP_ZERO: begin
        queue_frame(HDR_ZERO, 1'b1);
      end
      OP_TICK: begin
        if (ramping) begin
          limit = int'(step);
          // move each channel one step toward its goal, or snap when close
          for (int ch = 0; ch < CHANNELS; ch++) begin
            gap = int'(goal[ch]) - int'(position[ch]);
            if (gap > limit)
              position[ch] = position[ch] + step;
            else if (gap < -limit)
              position[ch] = position[ch] - step;
            else
              position[ch] = goal[ch];
          end
          queue_frame(HDR_MOVE, 1'b0);
          // ramp ends once all channels are inside the tolerance
          arrived = 1'b1;
          for (int ch = 0; ch < CHANNELS; ch++) begin
            gap = int'(goal[ch]) - int'(position[ch]);
            if (gap < 0)
              gap = -gap;
            if (gap > int'(tol))
              arrived = 1'b0;
          end
          if (arrived)
            ramping = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      step    = STEP_RESET;
      tol     = TOL_RESET;
      ramping = 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        position[ch] = '0;
        goal[ch]     = '0;
      end
      expected_beats.delete();
    end else begin
      // compare each accepted frame byte with the oldest prediction
      if (frame.valid && frame.ready) begin
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("%0t: unexpected frame byte %02h last %b", $realtime,
                     frame.frame_byte, frame.last_byte);
        end else begin
          want = expected_beats.pop_front();
          if (want.data !== frame.frame_byte || want.last !== frame.last_byte) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
              $display("%0t: frame byte mismatch: expected %02h last %b, got %02h last %b",
                       $realtime, want.data, want.last, frame.frame_byte, frame.last_byte);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        take_request(cmd.opcode, {cmd.target_3, cmd.target_2, cmd.target_1, cmd.target_0});
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (slf_reg_t'(paddr[2]))
          REG_STEP: step = pwdata[POS_W-1:0];
          REG_TOL:  tol  = pwdata[POS_W-1:0];
          default: ;
        endcase
      end
    end
    failures <= fail_count;
    pending  <= expected_beats.size();
  end

endmodule

// ===== test/testbench.sv =====
// top of the framer testbench: clock, reset, register writes, requests and verdict
module testbench
  import slf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF     = 6;
  localparam int          RESET_CYCLES = 12;
  localparam int          ITEM_GOAL    = 460;
  localparam int          CALM_ITEMS   = 60;
  localparam int          DRAIN_CYCLES = 2*CHANNELS_DEF + 3 + 4;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [2:0]  ADDR_STEP    = {REG_STEP, 2'b00};
  localparam logic [2:0]  ADDR_TOL     = {REG_TOL, 2'b00};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slf_cmd_if   cmd();
  slf_frame_if frame();

  int unsigned fail_total;
  int unsigned pending_bytes;
  int unsigned cycle_count;
  int unsigned work_items = 0;
  int unsigned next_config_at;
  bit          calm = 1'b0;
  logic [15:0] last_goal [TARGET_FIELDS] = '{default: '0};

  slew_limited_position_framer dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd),
    .frame   (frame)
  );

  slf_frame_checker frame_check (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .cmd      (cmd),
    .frame    (frame),
    .failures (fail_total),
    .pending  (pending_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // frame sink: random stall bursts, always ready near the end
  initial begin
    frame.ready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 9)) begin
          @(negedge clk);
          frame.ready <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 16)) begin
          @(negedge clk);
          frame.ready <= 1'b1;
        end
      end
    end
  end

  // optional sender gap before a request
  task automatic sender_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        cmd.valid <= 1'b0;
      end
    end
  endtask

  // present one request and hold it until accepted
  task automatic send_request(input logic [1:0] op, input logic [63:0] targets);
    sender_pause();
    @(negedge clk);
    cmd.valid    <= 1'b1;
    cmd.opcode   <= op;
    cmd.target_0 <= targets[15:0];
    cmd.target_1 <= targets[31:16];
    cmd.target_2 <= targets[47:32];
    cmd.target_3 <= targets[63:48];
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (op == OP_LOAD)
      for (int ch = 0; ch < TARGET_FIELDS; ch++)
        last_goal[ch] = targets[ch*16 +: 16];
    if (op != OP_UNUSED)
      work_items++;
  endtask

  // wait until every predicted byte has come out and the block is idle
  task automatic drain();
    @(negedge clk);
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] step, input logic [15:0] tol);
    drain();
    apb_write(ADDR_STEP, {16'h0000, step});
    apb_write(ADDR_TOL, {16'h0000, tol});
  endtask

  // new goal: full range, an extreme, or close to the previous goal
  function automatic logic [15:0] pick_target(input logic [15:0] near);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2:       return near + 16'($urandom_range(0, 600)) - 16'd300;
      default: return near + 16'($urandom_range(0, 40)) - 16'd20;
    endcase
  endfunction

  function automatic logic [63:0] pick_targets();
    logic [63:0] t;
    for (int ch = 0; ch < TARGET_FIELDS; ch++)
      t[ch*16 +: 16] = pick_target(last_goal[ch]);
    return t;
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      5:       return 16'($urandom);
      default: return 16'($urandom_range(2, 16'h0800));
    endcase
  endfunction

  function automatic logic [15:0] pick_tol();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 64));
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    int unsigned ticks;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cmd.valid    <= 1'b0;
    cmd.opcode   <= OP_LOAD;
    cmd.target_0 <= '0;
    cmd.target_1 <= '0;
    cmd.target_2 <= '0;
    cmd.target_3 <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: idle tick, zero frame, unused opcode, short ramp
    send_request(OP_TICK, 64'h0);
    send_request(OP_ZERO, 64'h0);
    send_request(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_LOAD, {16'h0006, 16'h0001, 16'h0000, 16'h0003});
    repeat (3) send_request(OP_TICK, 64'h0);

    // widest step, no tolerance: every channel snaps in one tick
    configure(16'hFFFF, 16'h0000);
    send_request(OP_LOAD, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
    send_request(OP_TICK, 64'h0);
    send_request(OP_TICK, 64'h0);
    send_request(OP_ZERO, 64'h0);

    // zero step: only channels already on goal settle, frame repeats
    configure(16'h0000, 16'h0000);
    send_request(OP_LOAD, {16'h7FFF, 16'h8000, 16'hFFFE, 16'h0001});
    send_request(OP_TICK, 64'h0);
    send_request(OP_TICK, 64'h0);
    send_request(OP_UNUSED, 64'h0);
    send_request(OP_LOAD, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
    send_request(OP_TICK, 64'h0);

    // mid-size step crossing byte boundaries
    configure(16'h0100, 16'h0003);
    send_request(OP_LOAD, {16'hFF00, 16'h00FF, 16'hABCD, 16'h1234});
    repeat (3) send_request(OP_TICK, 64'h0);
    send_request(OP_ZERO, 64'h0);
    send_request(OP_TICK, 64'h0);

    // random phases: a load followed by a run of ticks, with some noise
    next_config_at = work_items;
    while (work_items < ITEM_GOAL) begin
      if (work_items >= next_config_at) begin
        configure(pick_step(), pick_tol());
        next_config_at = work_items + $urandom_range(40, 80);
      end
      if (work_items >= ITEM_GOAL - CALM_ITEMS)
        calm = 1'b1;
      send_request(OP_LOAD, pick_targets());
      ticks = $urandom_range(1, 12);
      repeat (ticks) begin
        case ($urandom_range(0, 19))
          0, 1:    send_request(OP_ZERO, 64'h0);
          2:       send_request(OP_UNUSED, {$urandom, $urandom});
          default: send_request(OP_TICK, {$urandom, $urandom});
        endcase
      end
    end

    drain();
    if (fail_total == 0 && pending_bytes == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/slf_pkg.sv
hw/rtl/slf_cmd_if.sv
hw/rtl/slf_frame_if.sv
hw/rtl/slf_cell.sv
hw/rtl/slew_limited_position_framer.sv
hw/rtl/slf_checker.sv
test/slf_frame_checker.sv
test/testbench.sv
